// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants, command and status types for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int GROUP_BITS     = 32;
  localparam int CNT_W          = 16;
  localparam int ADDR_W         = 27;
  localparam int STATUS_W       = 2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADREQ  = 2'd2;

  localparam logic [1:0] MODE_ONE   = 2'd0;
  localparam logic [1:0] MODE_SMALL = 2'd1;
  localparam logic [1:0] MODE_LARGE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic init;      // zero map word at group index
    logic load;      // capture request
    logic clr_grp;   // group index to zero
    logic inc_grp;   // advance group index
    logic rd;        // issue map read at group index
    logic eval;      // evaluate read word
    logic set_grp;   // group index to start group
    logic wr;        // write modified word
    logic post;      // drive result
  } pba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;       // request invalid
    logic is_free;   // free request
    logic last_grp;  // index at last group
    logic found;     // evaluated word completes a run
    logic reset_run; // scan run broken
    logic wr_last;   // current write is last group of run
  } pba_sts_t;

  function automatic logic [4:0] lowest_bit(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int k = 31; k >= 0; k--) begin
      if (v[k]) r = 5'(k);
    end
    return r;
  endfunction

endpackage

// ===== rtl/pba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for bitmap clear after reset, request check, bitmap scan and bitmap update.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output pba_pkg::pba_cmd_t cmd,
  input  pba_pkg::pba_sts_t sts
);
  import pba_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_WRD   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_INIT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.last_grp) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.inc_grp = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.is_free) begin
          state_nxt = S_WRD;
        end else begin
          cmd.clr_grp = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.found) begin
          cmd.set_grp = 1'b1;
          state_nxt = S_WRD;
        end else if (sts.last_grp) begin
          state_nxt = S_DONE;
        end else begin
          cmd.inc_grp = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_WRD: begin
        cmd.rd = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.inc_grp = 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_DONE: begin
        cmd.post = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pba_dp.sv =====
// ----------------------------------------------------------------------------
// pba_dp
// Bitmap memory, run search and run update datapath.
// ----------------------------------------------------------------------------
module pba_dp #(
  parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pba_pkg::pba_cmd_t              cmd,
  output pba_pkg::pba_sts_t              sts,
  input  logic                           in_action,
  input  logic [pba_pkg::CNT_W-1:0]      in_page_count,
  input  logic [pba_pkg::ADDR_W-1:0]     in_base_address,
  output logic                           out_valid,
  output logic [pba_pkg::STATUS_W-1:0]   out_status,
  output logic [pba_pkg::ADDR_W-1:0]     out_address
);
  import pba_pkg::*;

  localparam int GROUPS  = NUM_PAGES / GROUP_BITS;
  localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PBW     = $clog2(PAGE_BYTES);
  localparam int PW      = ADDR_W + 1;

  logic [31:0] mem [GROUPS];
  logic [31:0] rdata_r;

  logic                action_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [GW:0]         grp_r, grp_nxt;
  logic [GW:0]         start_r, start_nxt;
  logic [4:0]          off_r, off_nxt;
  logic [1:0]          mode;
  logic                bad_r;
  logic [STATUS_W-1:0] st_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                ovalid_r;
  logic                found_r;

  logic [PW-1:0]       fpage;
  logic [PW-1:0]       fend;
  logic [31:0]         run;
  logic [31:0]         mask;
  logic [31:0]         wmask;
  logic [5:0]          wlo;
  logic [CNT_W-1:0]    wlen;
  logic [CNT_W:0]      wsum;
  logic [31:0]         wdata;
  logic                eval_found;
  logic                reset_run;
  logic [63:0]         addr_full;

  // request page index and end for free checks
  assign fpage = PW'(base_r >> PBW);
  assign fend = fpage + PW'(cnt_r);

  assign mode = (cnt_r == CNT_W'(1)) ? MODE_ONE :
                (cnt_r <= CNT_W'(GROUP_BITS)) ? MODE_SMALL : MODE_LARGE;

  always_comb begin
    run = rdata_r;
    for (int j = 1; j < 32; j++) begin
      if (CNT_W'(j) < cnt_r) run = run & (rdata_r >> j);
    end
    mask = (rem_r >= CNT_W'(GROUP_BITS)) ? 32'hFFFF_FFFF
         : ((32'd1 << rem_r[4:0]) - 32'd1);
  end

  always_comb begin
    eval_found = 1'b0;
    reset_run = 1'b0;
    unique case (mode)
      MODE_ONE:   eval_found = (rdata_r != 32'd0);
      MODE_SMALL: eval_found = (run != 32'd0);
      default: begin
        if (rem_r > CNT_W'(GROUP_BITS)) begin
          reset_run = (rdata_r != 32'hFFFF_FFFF);
        end else begin
          eval_found = ((rdata_r & mask) == mask);
          reset_run = !eval_found;
        end
      end
    endcase
  end

  // write span within current group
  always_comb begin
    wlo  = (grp_r == start_r) ? {1'b0, off_r} : 6'd0;
    wlen = rem_r;
    wsum = (CNT_W+1)'(wlo) + (CNT_W+1)'(wlen);
    if (wsum >= (CNT_W+1)'(GROUP_BITS)) begin
      wmask = 32'hFFFF_FFFF << wlo[4:0];
    end else begin
      wmask = ((32'd1 << wlen[4:0]) - 32'd1) << wlo[4:0];
    end
    wdata = action_r ? (rdata_r | wmask) : (rdata_r & ~wmask);
  end

  assign sts.found     = eval_found;
  assign sts.reset_run = reset_run;
  assign sts.bad       = bad_r;
  assign sts.is_free   = action_r;
  assign sts.last_grp  = (grp_r == (GW+1)'(GROUPS - 1));
  assign sts.wr_last   = (wsum <= (CNT_W+1)'(GROUP_BITS));

  always_comb begin
    bad_r = 1'b0;
    if (cnt_r == '0) bad_r = 1'b1;
    else if (!action_r) bad_r = ({16'd0, cnt_r} > 32'(NUM_PAGES));
    else bad_r = (base_r[PBW-1:0] != '0) ||
                 ({{(64-PW){1'b0}}, fend} > 64'(GROUPS * GROUP_BITS));
  end

  always_comb begin
    rem_nxt   = rem_r;
    grp_nxt   = grp_r;
    start_nxt = start_r;
    off_nxt   = off_r;
    if (cmd.load) begin
      rem_nxt = in_page_count;
    end
    if (cmd.clr_grp) begin
      grp_nxt = '0;
      start_nxt = '0;
      rem_nxt = cnt_r;
    end
    if (cmd.eval) begin
      if (mode == MODE_LARGE) begin
        if (reset_run) begin
          rem_nxt = cnt_r;
          start_nxt = grp_r + 1'b1;
        end else if (!eval_found) begin
          rem_nxt = rem_r - CNT_W'(GROUP_BITS);
        end
      end else begin
        start_nxt = grp_r;
        off_nxt = lowest_bit(mode == MODE_ONE ? rdata_r : run);
      end
    end
    if (cmd.inc_grp) grp_nxt = grp_r + 1'b1;
    if (cmd.set_grp) begin
      grp_nxt = (mode == MODE_LARGE) ? start_r : grp_r;
      rem_nxt = cnt_r;
      if (mode == MODE_LARGE) off_nxt = '0;
    end
    if (cmd.wr) rem_nxt = rem_r - (CNT_W'(GROUP_BITS) - CNT_W'(wlo));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      cnt_r    <= in_page_count;
      base_r   <= in_base_address;
    end
    if (!rst_n) begin
      grp_r   <= '0;
      start_r <= '0;
      off_r   <= '0;
    end else if (cmd.load && in_action) begin
      grp_r   <= (GW+1)'(PW'(in_base_address >> PBW) >> 5);
      start_r <= (GW+1)'(PW'(in_base_address >> PBW) >> 5);
      off_r   <= 5'(in_base_address >> PBW);
    end else begin
      grp_r   <= grp_nxt;
      start_r <= start_nxt;
      off_r   <= off_nxt;
    end
    rem_r <= rem_nxt;
    if (cmd.rd) rdata_r <= mem[grp_r[GW-1:0]];
    if (cmd.wr) mem[grp_r[GW-1:0]] <= wdata;
    else if (cmd.init) mem[grp_r[GW-1:0]] <= '0;
    if (cmd.load) found_r <= 1'b0;
    else if (cmd.eval && eval_found) found_r <= 1'b1;
  end

  assign addr_full = ({{(63-GW){1'b0}}, start_r} * 64'd32 + 64'(off_r)) * 64'(PAGE_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else        ovalid_r <= cmd.post;
    if (cmd.post) begin
      if (bad_r) begin
        st_r <= ST_BADREQ;
        addr_r <= '0;
      end else if (action_r) begin
        st_r <= ST_DONE;
        addr_r <= '0;
      end else if (found_r) begin
        st_r <= ST_DONE;
        addr_r <= addr_full[ADDR_W-1:0];
      end else begin
        st_r <= ST_NOSPACE;
        addr_r <= '0;
      end
    end
  end

  assign out_valid   = ovalid_r;
  assign out_status  = st_r;
  assign out_address = addr_r;

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// A rejected request goes from the check straight to the result; a free does a
// read and a write per group of its run; an allocate scans groups, then writes.
// One request at a time; busy stays high until the result strobe.
// Reset zeroes the bitmap (every page in use) group by group (NUM_PAGES/32
// groups) with busy high; software frees pages afterwards.
// The receiver cannot stall; out_valid lasts one cycle.
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap page frame allocator: controller plus bitmap datapath.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [pba_pkg::CNT_W-1:0]    in_page_count,
  input  logic [pba_pkg::ADDR_W-1:0]   in_base_address,
  output logic                         out_valid,
  output logic [pba_pkg::STATUS_W-1:0] out_status,
  output logic [pba_pkg::ADDR_W-1:0]   out_address
);
  import pba_pkg::*;

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  pba_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_page_count   (in_page_count),
    .in_base_address (in_base_address),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address     (out_address)
  );

endmodule

// ===== dv/page_bitmap_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_test
// Drives allocate and free requests into the page bitmap allocator and checks
// every result against a bitmap predictor kept in the scoreboard.
// ----------------------------------------------------------------------------
class pba_scoreboard;
  localparam int NGRP = pba_pkg::NUM_PAGES_DEF / pba_pkg::GROUP_BITS;
  localparam int PB   = pba_pkg::PAGE_BYTES_DEF;

  typedef struct {
    logic [pba_pkg::STATUS_W-1:0] status;
    logic [pba_pkg::ADDR_W-1:0]   address;
  } result_t;

  bit [31:0] free_map[NGRP];
  result_t   pending[$];
  int        mismatches;
  int        n_alloc, n_free, n_bad, n_nospace;
  int        last_page;

  function int low_set(bit [31:0] v);
    for (int k = 0; k < 32; k++) if (v[k]) return k;
    return 0;
  endfunction

  function void take_run(int first, int cnt);
    for (int k = first; k < first + cnt; k++) if (k < NGRP * 32) free_map[k / 32][k % 32] = 0;
  endfunction

  function bit find_run(int cnt, output int first);
    bit [31:0] g, run, mask;
    int remaining, strt;
    if (cnt == 1) begin
      for (int i = 0; i < NGRP; i++) if (free_map[i] != 0) begin
        first = i * 32 + low_set(free_map[i]);
        return 1;
      end
      return 0;
    end
    if (cnt <= 32) begin
      for (int i = 0; i < NGRP; i++) begin
        g = free_map[i];
        run = g;
        for (int j = 1; j < cnt; j++) run &= g >> j;
        if (run != 0) begin
          first = i * 32 + low_set(run);
          return 1;
        end
      end
      return 0;
    end
    remaining = cnt;
    strt = 0;
    for (int i = 0; i < NGRP; i++) begin
      g = free_map[i];
      if (remaining > 32) begin
        if (g != 32'hFFFF_FFFF) begin
          remaining = cnt;
          strt = i + 1;
        end else begin
          remaining -= 32;
        end
      end else begin
        mask = (remaining >= 32) ? 32'hFFFF_FFFF : ((32'd1 << remaining) - 1);
        if ((g & mask) == mask) begin
          first = strt * 32;
          return 1;
        end
        remaining = cnt;
        strt = i + 1;
      end
    end
    return 0;
  endfunction

  // returns 1 when an allocate succeeded; last_page holds its first page
  function bit note_request(bit act, bit [15:0] cnt, bit [26:0] base);
    result_t r;
    int first;
    int page;
    bit ok;
    r.status = pba_pkg::ST_DONE;
    r.address = '0;
    ok = 0;
    if (cnt == 0) begin
      r.status = pba_pkg::ST_BADREQ;
    end else if (act == 0) begin
      if (cnt > pba_pkg::NUM_PAGES_DEF) begin
        r.status = pba_pkg::ST_BADREQ;
      end else if (find_run(cnt, first)) begin
        take_run(first, cnt);
        r.address = 27'(longint'(first) * PB);
        last_page = first;
        ok = 1;
      end else begin
        r.status = pba_pkg::ST_NOSPACE;
      end
    end else begin
      page = base / PB;
      if (base % PB != 0 || page + cnt > NGRP * 32) begin
        r.status = pba_pkg::ST_BADREQ;
      end else begin
        for (int k = page; k < page + cnt; k++) free_map[k / 32][k % 32] = 1;
      end
    end
    if (r.status == pba_pkg::ST_BADREQ) n_bad++;
    else if (r.status == pba_pkg::ST_NOSPACE) n_nospace++;
    else if (act) n_free++;
    else n_alloc++;
    pending.push_back(r);
    return ok;
  endfunction

  function void check_result(logic [1:0] st, logic [26:0] addr);
    result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d address %h", st, addr);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status || addr !== e.address) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                 e.status, st, e.address, addr);
    end
  endfunction
endclass

module page_bitmap_allocator_test;
  import pba_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic              in_action = 0;
  logic [CNT_W-1:0]  in_page_count = '0;
  logic [ADDR_W-1:0] in_base_address = '0;
  logic              out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0] out_address;

  pba_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;
  int live_base[$];
  int live_cnt[$];

  page_bitmap_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_page_count(in_page_count),
    .in_base_address(in_base_address), .out_valid(out_valid),
    .out_status(out_status), .out_address(out_address)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_address);
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("timeout waiting for a transaction");
      $display("** page_bitmap_allocator: FAILED **");
      $finish;
    end
  end

  task automatic send(int act, int cnt, int base);
    start <= 1;
    in_action <= act[0];
    in_page_count <= cnt[CNT_W-1:0];
    in_base_address <= base[ADDR_W-1:0];
    do @(posedge clk); while (busy);
    if (sb.note_request(act[0], cnt[CNT_W-1:0], base[ADDR_W-1:0])) begin
      live_base.push_back(sb.last_page);
      live_cnt.push_back(int'(cnt[CNT_W-1:0]));
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  task automatic random_item();
    int sel, idx, cnt;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // noise: zero, oversized, misaligned or past-end requests
      case ($urandom_range(3))
        0: send($urandom_range(1), 0, $urandom);
        1: send(0, $urandom_range(65535, 32769), $urandom);
        2: send(1, $urandom_range(1, 64), ($urandom_range(32767) << 12) | $urandom_range(4095, 1));
        default: send(1, $urandom_range(65535, 2), $urandom_range(32767, 32700) << 12);
      endcase
    end else if (sel < 48 || live_base.size() > 60) begin
      if (live_base.size() == 0) begin
        send(1, $urandom_range(1, 32), $urandom_range(32767 - 32) << 12);
      end else begin
        idx = $urandom_range(live_base.size() - 1);
        cnt = live_cnt[idx];
        // free the whole run or just part of it
        if ($urandom_range(3) == 0) cnt = $urandom_range(cnt, 1);
        send(1, cnt, live_base[idx] << 12);
        live_base.delete(idx);
        live_cnt.delete(idx);
      end
    end else begin
      sel = $urandom_range(99);
      if (sel < 30) cnt = 1;
      else if (sel < 75) cnt = $urandom_range(32, 2);
      else if (sel < 97) cnt = $urandom_range(300, 33);
      else cnt = $urandom_range(32768, 4000);
      send(0, cnt, $urandom);
    end
  endtask

  initial begin
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send(0, 1, 0);
    send(0, 40, 0);
    send(1, 32768, 0);
    send(0, 1, 0);
    send(0, 2, 32'h07FF_FFFF);
    send(0, 32, 0);
    send(0, 33, 0);
    send(0, 64, 0);
    send(0, 1000, 0);
    send(0, 0, 0);
    send(1, 0, 0);
    send(0, 32769, 0);
    send(0, 32'h0000_FFFF, 0);
    send(1, 1, 32'h0000_0FFF);
    send(1, 2, 32'h07FF_F000);
    send(1, 1, 32'h07FF_F000);
    send(1, 64, 32'h0040_0000);
    send(0, 32768, 0);
    send(1, 32768, 0);
    send(0, 32768, 0);
    send(0, 1, 0);
    send(0, 40, 0);
    send(1, 32768, 0);
    send(1, 32'h0000_FFFF, 32'h0555_5000);

    // random, in idling phases
    for (int i = 0; i < 600; i++) begin
      case (i / 150)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 13;
      endcase
      random_item();
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d allocations, %0d frees, %0d rejected, %0d out of space",
             sb.n_alloc, sb.n_free, sb.n_bad, sb.n_nospace);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** page_bitmap_allocator: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** page_bitmap_allocator: FAILED **");
    end
    $finish;
  end
endmodule
